@@ hw/rtl/ptfp_pkg.sv @@
// Shared constants, angle tables and payload types for the pan/tilt floor point pipeline.
`default_nettype none

package ptfp_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int CORDIC_STEPS   = 30;
  localparam int ZW             = 33;
  localparam int XW             = 33;
  localparam int NW             = 34;
  localparam int DIVW           = 64;
  localparam int DVW            = 31;
  localparam int QW             = 33;

  localparam longint PI_Q30     = 64'sd3373259426;
  localparam longint HALFPI_Q30 = 64'sd1686629713;

  function automatic longint atan_q30(input int idx);
    case (idx)
      0:       atan_q30 = 64'sd843314857;
      1:       atan_q30 = 64'sd497837829;
      2:       atan_q30 = 64'sd263043837;
      3:       atan_q30 = 64'sd133525159;
      4:       atan_q30 = 64'sd67021687;
      5:       atan_q30 = 64'sd33543516;
      6:       atan_q30 = 64'sd16775851;
      7:       atan_q30 = 64'sd8388437;
      8:       atan_q30 = 64'sd4194283;
      9:       atan_q30 = 64'sd2097149;
      default: atan_q30 = longint'(1) <<< (30 - idx);
    endcase
  endfunction

  function automatic longint cordic_gain_x();
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = longint'(1) <<< 30;
    y = 0;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_q30(i);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_q30(i);
      end
    end
    cordic_gain_x = x;
  endfunction

  localparam longint GainX        = cordic_gain_x();
  localparam longint GAIN_FIX_Q30 = ((longint'(1) <<< 60) + GainX / 2) / GainX;

  typedef struct packed {
    logic signed [ZW-1:0] zp;
    logic signed [ZW-1:0] zt;
    logic                 fold;
  } angle_t;

  typedef struct packed {
    logic signed [XW-1:0] cp;
    logic signed [XW-1:0] sp;
    logic signed [XW-1:0] ct;
    logic signed [XW-1:0] st;
  } trig_t;

  typedef struct packed {
    logic neg;
    logic zero;
    logic ct_le0;
  } coord_flag_t;

  typedef struct packed {
    logic [QW-1:0] quo;
    logic          ovf;
    coord_flag_t   flag;
  } quot_t;

  typedef struct packed {
    logic        clip;
    logic [31:0] fy;
    logic [31:0] fx;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/ptfp_angle.sv @@
// Maps the pan and tilt codes to Q30 radian angles and folds the pan angle.
`default_nettype none

module ptfp_angle #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [15:0]     pan_code_i,
  input  wire logic [15:0]     tilt_code_i,
  output logic                 valid_o,
  output ptfp_pkg::angle_t     angle_o
);
  import ptfp_pkg::*;

  localparam int A   = ANGLE_BITS;
  localparam int M   = (1 << A) - 1;
  localparam int FA  = 2 * A + 2;
  localparam int RW  = A + 34;
  localparam int HW  = RW - 25;
  localparam int PW  = 2 * A + 34;
  localparam logic [127:0] RNum = (128'(PI_Q30) << FA) + 128'(M - 1);
  localparam logic [127:0] RVal = RNum / 128'(M);
  localparam logic [24:0]   RLo = RVal[24:0];
  localparam logic [HW-1:0] RHi = RVal[RW-1:25];
  localparam logic signed [A+1:0]  MS     = (A + 2)'(M);
  localparam logic signed [ZW-1:0] PiZ    = ZW'(PI_Q30);
  localparam logic signed [ZW-1:0] HalfPiZ = ZW'(HALFPI_Q30);

  logic [4:0] v_q;

  logic signed [A+1:0] sp_s;
  logic signed [A+1:0] st_s;
  logic [A-1:0] magp_q;
  logic [A-1:0] magt_q;
  logic [4:0]   negp_q;
  logic [4:0]   negt_q;

  logic [A+24:0]  plo_q;
  logic [A+HW-1:0] phi_q;
  logic [A+24:0]  tlo_q;
  logic [A+HW-1:0] thi_q;

  logic [PW:0]  pprod;
  logic [PW:0]  tprod;
  logic [31:0]  ap_q;
  logic [30:0]  at_q;

  logic signed [ZW-1:0] zp_q;
  logic signed [ZW-1:0] zt_q;
  angle_t               out_q;

  assign sp_s = $signed({1'b0, pan_code_i[15 -: A], 1'b0}) - MS;
  assign st_s = $signed({1'b0, tilt_code_i[15 -: A], 1'b0}) - MS;

  assign pprod = ((PW + 1)'(phi_q) << 25) + (PW + 1)'(plo_q) + ((PW + 1)'(1) << (FA - 1));
  assign tprod = ((PW + 1)'(thi_q) << 25) + (PW + 1)'(tlo_q) + ((PW + 1)'(1) << FA);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      magp_q <= sp_s[A+1] ? A'(-sp_s) : A'(sp_s);
      magt_q <= st_s[A+1] ? A'(-st_s) : A'(st_s);
      negp_q <= {negp_q[3:0], sp_s[A+1]};
      negt_q <= {negt_q[3:0], st_s[A+1]};
      plo_q  <= (A + 25)'(magp_q) * (A + 25)'(RLo);
      phi_q  <= (A + HW)'(magp_q) * (A + HW)'(RHi);
      tlo_q  <= (A + 25)'(magt_q) * (A + 25)'(RLo);
      thi_q  <= (A + HW)'(magt_q) * (A + HW)'(RHi);
      ap_q   <= pprod[FA+31:FA];
      at_q   <= tprod[FA+31:FA+1];
      zp_q   <= negp_q[2] ? -$signed({1'b0, ap_q}) : $signed({1'b0, ap_q});
      zt_q   <= negt_q[2] ? -$signed({2'b0, at_q}) : $signed({2'b0, at_q});
      out_q.zt <= zt_q;
      if (zp_q > HalfPiZ) begin
        out_q.zp   <= zp_q - PiZ;
        out_q.fold <= 1'b1;
      end else if (zp_q < -HalfPiZ) begin
        out_q.zp   <= zp_q + PiZ;
        out_q.fold <= 1'b1;
      end else begin
        out_q.zp   <= zp_q;
        out_q.fold <= 1'b0;
      end
    end
  end

  assign valid_o = v_q[4];
  assign angle_o = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/ptfp_cordic.sv @@
// Pipelined rotation-mode CORDIC giving pan and tilt sine and cosine in Q30.
`default_nettype none

module ptfp_cordic (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire ptfp_pkg::angle_t angle_i,
  output logic                 valid_o,
  output logic                 fold_o,
  output ptfp_pkg::trig_t      trig_o
);
  import ptfp_pkg::*;

  localparam logic signed [XW-1:0] GainInit = XW'(GAIN_FIX_Q30);

  logic signed [XW-1:0] px_q [CORDIC_STEPS];
  logic signed [XW-1:0] py_q [CORDIC_STEPS];
  logic signed [ZW-1:0] pz_q [CORDIC_STEPS];
  logic signed [XW-1:0] tx_q [CORDIC_STEPS];
  logic signed [XW-1:0] ty_q [CORDIC_STEPS];
  logic signed [ZW-1:0] tz_q [CORDIC_STEPS];
  logic [CORDIC_STEPS-1:0] fold_q;
  logic [CORDIC_STEPS-1:0] v_q;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] Atan = ZW'(atan_q30(i));
    logic signed [XW-1:0] px_in;
    logic signed [XW-1:0] py_in;
    logic signed [ZW-1:0] pz_in;
    logic signed [XW-1:0] tx_in;
    logic signed [XW-1:0] ty_in;
    logic signed [ZW-1:0] tz_in;
    logic                 f_in;
    logic                 v_in;

    if (i == 0) begin : g_first
      assign px_in = GainInit;
      assign py_in = '0;
      assign pz_in = angle_i.zp;
      assign tx_in = GainInit;
      assign ty_in = '0;
      assign tz_in = angle_i.zt;
      assign f_in  = angle_i.fold;
      assign v_in  = valid_i;
    end else begin : g_next
      assign px_in = px_q[i-1];
      assign py_in = py_q[i-1];
      assign pz_in = pz_q[i-1];
      assign tx_in = tx_q[i-1];
      assign ty_in = ty_q[i-1];
      assign tz_in = tz_q[i-1];
      assign f_in  = fold_q[i-1];
      assign v_in  = v_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        fold_q[i] <= f_in;
        if (pz_in >= 0) begin
          px_q[i] <= px_in - (py_in >>> i);
          py_q[i] <= py_in + (px_in >>> i);
          pz_q[i] <= pz_in - Atan;
        end else begin
          px_q[i] <= px_in + (py_in >>> i);
          py_q[i] <= py_in - (px_in >>> i);
          pz_q[i] <= pz_in + Atan;
        end
        if (tz_in >= 0) begin
          tx_q[i] <= tx_in - (ty_in >>> i);
          ty_q[i] <= ty_in + (tx_in >>> i);
          tz_q[i] <= tz_in - Atan;
        end else begin
          tx_q[i] <= tx_in + (ty_in >>> i);
          ty_q[i] <= ty_in - (tx_in >>> i);
          tz_q[i] <= tz_in + Atan;
        end
      end
    end
  end

  assign valid_o   = v_q[CORDIC_STEPS-1];
  assign fold_o    = fold_q[CORDIC_STEPS-1];
  assign trig_o.cp = px_q[CORDIC_STEPS-1];
  assign trig_o.sp = py_q[CORDIC_STEPS-1];
  assign trig_o.ct = tx_q[CORDIC_STEPS-1];
  assign trig_o.st = ty_q[CORDIC_STEPS-1];

endmodule

`default_nettype wire

@@ hw/rtl/ptfp_proj.sv @@
// Applies the pan fold, forms the beam products and builds the rounded dividends.
`default_nettype none

module ptfp_proj #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire logic                  fold_i,
  input  wire ptfp_pkg::trig_t       trig_i,
  output logic                       valid_o,
  output logic [ptfp_pkg::DIVW-1:0]  dividend_x_o,
  output logic [ptfp_pkg::DIVW-1:0]  dividend_y_o,
  output logic [ptfp_pkg::DVW-1:0]   divisor_o,
  output ptfp_pkg::coord_flag_t      flag_x_o,
  output ptfp_pkg::coord_flag_t      flag_y_o
);
  import ptfp_pkg::*;

  logic [2:0] v_q;
  trig_t      a_q;
  logic signed [NW-1:0] nx_q;
  logic signed [NW-1:0] ny_q;
  logic signed [XW-1:0] ctb_q;
  logic signed [2*XW-1:0] prod_x;
  logic signed [2*XW-1:0] prod_y;
  logic [NW-1:0] mag_x;
  logic [NW-1:0] mag_y;

  logic [DIVW-1:0] dx_q;
  logic [DIVW-1:0] dy_q;
  logic [DVW-1:0]  dv_q;
  coord_flag_t     fx_q;
  coord_flag_t     fy_q;

  assign prod_x = a_q.st * a_q.sp;
  assign prod_y = a_q.st * a_q.cp;
  assign mag_x  = nx_q[NW-1] ? NW'(-nx_q) : NW'(nx_q);
  assign mag_y  = ny_q[NW-1] ? NW'(-ny_q) : NW'(ny_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q.ct <= trig_i.ct;
      a_q.st <= trig_i.st;
      a_q.cp <= fold_i ? -trig_i.cp : trig_i.cp;
      a_q.sp <= fold_i ? -trig_i.sp : trig_i.sp;
      nx_q   <= prod_x[NW+29:30];
      ny_q   <= prod_y[NW+29:30];
      ctb_q  <= a_q.ct;
      dx_q   <= (DIVW'(mag_x) << (FRAC_BITS - 1)) + DIVW'(ctb_q[DVW-1:1]);
      dy_q   <= (DIVW'(mag_y) << (FRAC_BITS - 1)) + DIVW'(ctb_q[DVW-1:1]);
      dv_q   <= ctb_q[DVW-1:0];
      fx_q.neg    <= nx_q[NW-1];
      fx_q.zero   <= (nx_q == '0);
      fx_q.ct_le0 <= (ctb_q <= 0);
      fy_q.neg    <= ny_q[NW-1];
      fy_q.zero   <= (ny_q == '0);
      fy_q.ct_le0 <= (ctb_q <= 0);
    end
  end

  assign valid_o      = v_q[2];
  assign dividend_x_o = dx_q;
  assign dividend_y_o = dy_q;
  assign divisor_o    = dv_q;
  assign flag_x_o     = fx_q;
  assign flag_y_o     = fy_q;

endmodule

`default_nettype wire

@@ hw/rtl/ptfp_div.sv @@
// Pipelined restoring divider: an overflow precheck stage, then one quotient bit per stage.
`default_nettype none

module ptfp_div (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire logic [ptfp_pkg::DIVW-1:0] dividend_i,
  input  wire logic [ptfp_pkg::DVW-1:0]  divisor_i,
  input  wire ptfp_pkg::coord_flag_t flag_i,
  output logic                       valid_o,
  output ptfp_pkg::quot_t            quot_o
);
  import ptfp_pkg::*;

  localparam int NS = QW + 1;

  logic [DIVW-1:0] r_q   [NS];
  logic [DVW-1:0]  d_q   [NS];
  logic [QW-1:0]   q_q   [NS];
  coord_flag_t     f_q   [NS];
  logic [NS-1:0]   ovf_q;
  logic [NS-1:0]   v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= dividend_i;
      d_q[0]   <= divisor_i;
      q_q[0]   <= '0;
      f_q[0]   <= flag_i;
      ovf_q[0] <= ((DIVW + 1)'(dividend_i) >= ((DIVW + 1)'(divisor_i) << QW));
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_bit
    localparam int J = QW - k;
    logic [DIVW-1:0] sh;
    logic            ge;

    assign sh = DIVW'(d_q[k-1]) << J;
    assign ge = (r_q[k-1] >= sh);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]   <= ge ? r_q[k-1] - sh : r_q[k-1];
        q_q[k]   <= q_q[k-1] | (QW'(ge) << J);
        d_q[k]   <= d_q[k-1];
        f_q[k]   <= f_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign valid_o     = v_q[NS-1];
  assign quot_o.quo  = q_q[NS-1];
  assign quot_o.ovf  = ovf_q[NS-1];
  assign quot_o.flag = f_q[NS-1];

endmodule

`default_nettype wire

@@ hw/rtl/pan_tilt_to_floor_point.sv @@
// Top level: moving-head pan/tilt codes to the floor point hit by the beam.
//
// The input stream carries one code pair per transfer: pan in tdata[15:0] and tilt in
// tdata[31:16]. The output stream carries one result per input transfer, in order:
// floor x in tdata[31:0] and floor y in tdata[63:32], both signed with FRAC_BITS
// fraction bits, and the clipped flag in tuser.
// The block is a fixed pipeline of 73 register stages: angle mapping (5), two
// parallel 30-step CORDIC rotations (30), fold and products (3), two restoring
// dividers with an overflow precheck and one quotient bit per stage (34) and the
// output register (1). The transfer's edge loads the first stage, and one code pair
// is taken in every cycle while the receiver keeps up and tready stays high.
// Quotient bits of the dividers set the depth.
// Reset clears all valid bits and the skid register, so tready is high while reset
// is held and after it is released.
// When the receiver stalls, the output register holds its result and one further
// result lands in a skid register; only then does tready drop and the whole
// pipeline hold, so nothing is lost or repeated.
`default_nettype none

module pan_tilt_to_floor_point #(
  parameter int ANGLE_BITS = ptfp_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = ptfp_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // pan_code[15:0], tilt_code[31:16]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // floor_x[31:0], floor_y[63:32]
  output logic             m_axis_tuser    // clipped
);
  import ptfp_pkg::*;

  localparam logic signed [34:0] Half = 35'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [34:0] MaxV = 35'sd2147483647;
  localparam logic signed [34:0] MinV = -35'sd2147483648;

  logic en;
  logic ang_v;
  angle_t ang;
  logic cor_v;
  logic cor_fold;
  trig_t trig;
  logic prj_v;
  logic [DIVW-1:0] dvd_x;
  logic [DIVW-1:0] dvd_y;
  logic [DVW-1:0]  dvs;
  coord_flag_t fl_x;
  coord_flag_t fl_y;
  logic div_v;
  logic div_vy;
  quot_t qx;
  quot_t qy;
  logic [32:0] cx;
  logic [32:0] cy;
  result_t p_res;

  logic    out_vq;
  logic    skid_vq;
  result_t out_q;
  result_t skid_q;

  function automatic logic [32:0] coord(input quot_t q);
    logic signed [34:0] v;
    logic               clip;
    logic [31:0]        val;
    v    = '0;
    clip = 1'b0;
    val  = '0;
    if (q.flag.ct_le0) begin
      clip = 1'b1;
      if (q.flag.zero) begin
        val = 32'(Half);
      end else if (q.flag.neg) begin
        val = 32'(MaxV);
      end else begin
        val = 32'(MinV);
      end
    end else if (q.ovf) begin
      clip = 1'b1;
      val  = q.flag.neg ? 32'(MaxV) : 32'(MinV);
    end else begin
      v = q.flag.neg ? Half + $signed({2'b0, q.quo}) : Half - $signed({2'b0, q.quo});
      if (v > MaxV) begin
        clip = 1'b1;
        val  = 32'(MaxV);
      end else if (v < MinV) begin
        clip = 1'b1;
        val  = 32'(MinV);
      end else begin
        val = v[31:0];
      end
    end
    coord = {clip, val};
  endfunction

  assign en            = !skid_vq;
  assign s_axis_tready = en;

  ptfp_angle #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_angle (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s_axis_tvalid),
    .pan_code_i (s_axis_tdata[15:0]),
    .tilt_code_i(s_axis_tdata[31:16]),
    .valid_o    (ang_v),
    .angle_o    (ang)
  );

  ptfp_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(ang_v),
    .angle_i(ang),
    .valid_o(cor_v),
    .fold_o (cor_fold),
    .trig_o (trig)
  );

  ptfp_proj #(
    .FRAC_BITS(FRAC_BITS)
  ) u_proj (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (cor_v),
    .fold_i      (cor_fold),
    .trig_i      (trig),
    .valid_o     (prj_v),
    .dividend_x_o(dvd_x),
    .dividend_y_o(dvd_y),
    .divisor_o   (dvs),
    .flag_x_o    (fl_x),
    .flag_y_o    (fl_y)
  );

  ptfp_div u_div_x (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (prj_v),
    .dividend_i(dvd_x),
    .divisor_i (dvs),
    .flag_i    (fl_x),
    .valid_o   (div_v),
    .quot_o    (qx)
  );

  ptfp_div u_div_y (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (prj_v),
    .dividend_i(dvd_y),
    .divisor_i (dvs),
    .flag_i    (fl_y),
    .valid_o   (div_vy),
    .quot_o    (qy)
  );

  assign cx         = coord(qx);
  assign cy         = coord(qy);
  assign p_res.fx   = cx[31:0];
  assign p_res.fy   = cy[31:0];
  assign p_res.clip = cx[32] | cy[32] | (div_v & ~div_vy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq  <= 1'b0;
      skid_vq <= 1'b0;
    end else if (!out_vq || m_axis_tready) begin
      if (skid_vq) begin
        out_vq  <= 1'b1;
        skid_vq <= 1'b0;
      end else begin
        out_vq <= div_v;
      end
    end else if (div_v && !skid_vq) begin
      skid_vq <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vq || m_axis_tready) begin
      out_q <= skid_vq ? skid_q : p_res;
    end else if (!skid_vq) begin
      skid_q <= p_res;
    end
  end

  assign m_axis_tvalid = out_vq;
  assign m_axis_tdata  = {out_q.fy, out_q.fx};
  assign m_axis_tuser  = out_q.clip;

endmodule

`default_nettype wire

@@ dv/pan_tilt_to_floor_point_test.sv @@
// Self-checking stream testbench for the pan/tilt to floor point pipeline.
module pan_tilt_to_floor_point_test;

  localparam int HoldCycles = 400;
  localparam int StallLimit = 4000;
  localparam int Latency = 73;

  typedef struct {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic clip;
  } floor_point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic [31:0] s_tdata = '0;
  logic m_tready = 1'b0;
  wire s_tready;
  wire m_tvalid;
  wire [63:0] m_tdata;
  wire m_tuser;

  pan_tilt_to_floor_point u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata(m_tdata),
    .m_axis_tuser(m_tuser)
  );

  always #5 clk_i = ~clk_i;

  longint atan_tab[30];
  longint pi_fix;
  longint halfpi_fix;
  longint gain_fix;

  floor_point_t pending_points[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold = 0;
  int mismatches = 0;
  int sent = 0;
  int received = 0;
  int clipped_seen = 0;
  int stall_cycles = 0;

  function automatic longint round_div(longint a, longint b);
    if (a >= 0) return (a + b / 2) / b;
    return -((-a + b / 2) / b);
  endfunction

  function automatic longint arctan_inv(longint unsigned n);
    longint unsigned nn;
    longint unsigned p;
    longint unsigned k;
    longint sum;
    longint t;
    nn = n * n;
    p = (64'd1 << 62) / n;
    sum = 0;
    k = 0;
    while (p != 0) begin
      t = longint'(p / (2 * k + 1));
      sum += k[0] ? -t : t;
      p /= nn;
      k++;
    end
    return sum;
  endfunction

  task automatic cordic_rotate(input longint x0, input longint z0, output longint c,
                               output longint s);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = x0;
    y = 0;
    z = z0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    c = x;
    s = y;
  endtask

  task automatic build_angle_tables();
    longint a;
    longint c;
    longint s;
    a = arctan_inv(2) + arctan_inv(3);
    atan_tab[0] = (a + (64'sd1 << 31)) >>> 32;
    pi_fix = (a + (64'sd1 << 29)) >>> 30;
    halfpi_fix = (a + (64'sd1 << 30)) >>> 31;
    for (int i = 1; i < 30; i++) begin
      a = arctan_inv(64'd1 << i);
      atan_tab[i] = (a + (64'sd1 << 31)) >>> 32;
    end
    cordic_rotate(64'sd1 << 30, 0, c, s);
    gain_fix = ((64'sd1 << 60) + c / 2) / c;
  endtask

  function automatic longint floor_coord(longint n, longint ct, inout logic clip);
    longint half;
    longint v;
    half = 64'sd1 << 15;
    if (ct <= 0) begin
      clip = 1'b1;
      if (n > 0) return -64'sd2147483648;
      if (n < 0) return 64'sd2147483647;
      return half;
    end
    v = half - round_div(n * half, ct);
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647; clip = 1'b1;
    end
    if (v < -64'sd2147483648) begin
      v = -64'sd2147483648; clip = 1'b1;
    end
    return v;
  endfunction

  task automatic beam_floor_point(input logic [15:0] pan, input logic [15:0] tilt,
                                  output floor_point_t pt);
    longint m;
    longint zp;
    longint zt;
    longint sp;
    longint cp;
    longint st;
    longint ct;
    logic fold;
    logic clip;
    m = 65535;
    fold = 1'b0;
    clip = 1'b0;
    zp = round_div((2 * longint'(pan) - m) * pi_fix, m);
    zt = round_div((2 * longint'(tilt) - m) * pi_fix, 2 * m);
    if (zp > halfpi_fix) begin
      zp -= pi_fix; fold = 1'b1;
    end else if (zp < -halfpi_fix) begin
      zp += pi_fix; fold = 1'b1;
    end
    cordic_rotate(gain_fix, zp, cp, sp);
    if (fold) begin
      cp = -cp; sp = -sp;
    end
    cordic_rotate(gain_fix, zt, ct, st);
    pt.fx = 32'(floor_coord((st * sp) >>> 30, ct, clip));
    pt.fy = 32'(floor_coord((st * cp) >>> 30, ct, clip));
    pt.clip = clip;
  endtask

  task automatic send_codes(input logic [15:0] pan, input logic [15:0] tilt);
    floor_point_t pt;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {tilt, pan};
    beam_floor_point(pan, tilt, pt);
    do @(posedge clk_i); while (!s_tready);
    pending_points.insert(pending_points.size(), pt);
    sent++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_points.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_tilt();
    case ($urandom_range(2))
      0: return 16'($urandom_range(600));
      1: return 16'($urandom_range(65535, 64935));
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (recv_hold > 0) begin
      m_tready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else begin
      m_tready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  always @(posedge clk_i) begin
    floor_point_t want;
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("timeout with %0d results outstanding", pending_points.size());
      $display("pan_tilt_to_floor_point_test: errors");
      $finish;
    end
    if (m_tvalid && m_tready) begin
      received++;
      if (m_tuser) clipped_seen++;
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_tdata);
      end else begin
        want = pending_points.pop_front();
        if (m_tdata[31:0] !== want.fx || m_tdata[63:32] !== want.fy ||
            m_tuser !== want.clip) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected x %h y %h clip %b, got x %h y %h clip %b",
                     received, want.fx, want.fy, want.clip,
                     m_tdata[31:0], m_tdata[63:32], m_tuser);
        end
      end
    end
  end

  task automatic test_corners();
    logic [15:0] pans[10] = '{16'd0, 16'd16383, 16'd16384, 16'd32767, 16'd32768,
                               16'd49151, 16'd49152, 16'd65535, 16'h5555, 16'hAAAA};
    logic [15:0] tilts[8] = '{16'd0, 16'd1, 16'd32767, 16'd32768, 16'd65534,
                               16'd65535, 16'd16384, 16'd49151};
    for (int i = 0; i < 10; i++) send_codes(pans[i], tilts[i % 8]);
    for (int i = 0; i < 8; i++) send_codes(pans[(i * 3) % 10], tilts[i]);
    send_codes(16'd65535, 16'd65535);
    send_codes(16'd0, 16'd0);
    drain_results();
  endtask

  task automatic test_random(input int count, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < count; i++) send_codes(16'($urandom), rand_tilt());
    drain_results();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold <= HoldCycles;
    for (int i = 0; i < 200; i++) send_codes(16'($urandom), rand_tilt());
    drain_results();
  endtask

  initial begin
    build_angle_tables();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corners();
    test_random(550, 32, 67);
    test_random(550, 67, 32);
    test_backpressure();
    test_random(550, 0, 0);
    repeat (Latency + 10) @(posedge clk_i);
    $display("covered %0d code pairs incl. fold edges, horizontal tilt and long stall;",
             sent);
    $display("%0d results checked, %0d of them clipped", received, clipped_seen);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("pan_tilt_to_floor_point_test: clean");
    end else begin
      $display("%0d mismatches, %0d missing", mismatches, pending_points.size());
      $display("pan_tilt_to_floor_point_test: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/ptfp_pkg.sv
hw/rtl/ptfp_angle.sv
hw/rtl/ptfp_cordic.sv
hw/rtl/ptfp_proj.sv
hw/rtl/ptfp_div.sv
hw/rtl/pan_tilt_to_floor_point.sv
dv/pan_tilt_to_floor_point_test.sv
